/* rtl/bloom_filter_double_hash_top_assert.svh */
// Assertion macros for the Bloom filter block.
// Used by the top level; expects clk_i and rst_ni in the enclosing scope.
`ifndef BLOOM_FILTER_DOUBLE_HASH_TOP_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BFDH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfdh: implication check failed");

// Next-cycle implication, checked outside reset
`define BFDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfdh: next-cycle check failed");

`endif

/* rtl/bfdh_pkg.sv */
// Shared constants, register codes and types of the Bloom filter block.
// No dependencies; imported by every module of the block except bfdh_ram.
package bfdh_pkg;

  // Default build parameters
  localparam int unsigned FILTER_BITS_DEF = 16777216;
  localparam int unsigned HASH_WIDTH_DEF  = 64;

  // Configuration port
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_SIZE_W   = 25;
  localparam int unsigned CFG_PROBES_W = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_SIZE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_PROBE_COUNT = CFG_ADDR_W'(1);

  localparam logic [CFG_SIZE_W-1:0]   SIZE_RESET   = CFG_SIZE_W'(9585058);
  localparam logic [CFG_PROBES_W-1:0] PROBES_RESET = CFG_PROBES_W'(6);
  localparam logic [CFG_PROBES_W-1:0] MAX_PROBES   = CFG_PROBES_W'(32);

  // djb2 seed
  localparam int unsigned DJB2_INIT = 5381;

  // Filter store word organization
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_SH = 6;

  // Key operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Reduced hashes handed from the reduction unit to the probe unit
  typedef struct packed {
    logic                  valid;
    logic [CFG_SIZE_W-1:0] h1;
    logic [CFG_SIZE_W-1:0] h2;
  } reduce_res_t;

endpackage

/* rtl/bfdh_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bfdh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read old data, write new data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bfdh_hash.sv */
// Running djb2 and sdbm hash accumulators, one key character per item.
// Depends on bfdh_pkg.
module bfdh_hash import bfdh_pkg::*; #(
  parameter int unsigned HASH_WIDTH = HASH_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic signed [7:0]     key_char_i,
  input  logic                  char_present_i,
  input  logic                  key_last_i,
  output logic [HASH_WIDTH-1:0] djb2_next_o,
  output logic [HASH_WIDTH-1:0] sdbm_next_o
);

  logic [HASH_WIDTH-1:0] djb2_q, djb2_d;
  logic [HASH_WIDTH-1:0] sdbm_q, sdbm_d;
  logic [HASH_WIDTH-1:0] char_ext;

  // Sign-extend the character into the hash width
  assign char_ext = {{(HASH_WIDTH-8){key_char_i[7]}}, key_char_i};

  // Fold in the character when one is present
  always_comb begin
    djb2_next_o = djb2_q;
    sdbm_next_o = sdbm_q;
    if (char_present_i) begin
      djb2_next_o = (djb2_q << 5) + djb2_q + char_ext;
      sdbm_next_o = char_ext + (sdbm_q << 6) + (sdbm_q << 16) - sdbm_q;
    end
  end

  // Restart both hashes after the closing item of a key
  always_comb begin
    djb2_d = djb2_q;
    sdbm_d = sdbm_q;
    if (accept_i) begin
      if (key_last_i) begin
        djb2_d = HASH_WIDTH'(DJB2_INIT);
        sdbm_d = '0;
      end else begin
        djb2_d = djb2_next_o;
        sdbm_d = sdbm_next_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      djb2_q <= HASH_WIDTH'(DJB2_INIT);
      sdbm_q <= '0;
    end else begin
      djb2_q <= djb2_d;
      sdbm_q <= sdbm_d;
    end
  end

endmodule

/* rtl/bfdh_reduce.sv */
// Sequential reduction of both hashes modulo the filter size.
// One quotient bit per cycle, both hashes side by side. Depends on bfdh_pkg.
module bfdh_reduce import bfdh_pkg::*; #(
  parameter int unsigned HASH_WIDTH = HASH_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [HASH_WIDTH-1:0] djb2_i,
  input  logic [HASH_WIDTH-1:0] sdbm_i,
  input  logic [CFG_SIZE_W-1:0] m_i,
  output reduce_res_t           res_o
);

  localparam int unsigned CntW = $clog2(HASH_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(HASH_WIDTH - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CFG_SIZE_W-1:0] m_q, m_d;
  logic [HASH_WIDTH-1:0] dvd1_q, dvd1_d, dvd2_q, dvd2_d;
  logic [CFG_SIZE_W-1:0] rem1_q, rem1_d, rem2_q, rem2_d;

  // One restoring step: shift in a bit, subtract the modulus if it fits
  function automatic logic [CFG_SIZE_W-1:0] rem_step(
    input logic [CFG_SIZE_W-1:0] rem,
    input logic                  bit_in,
    input logic [CFG_SIZE_W-1:0] m
  );
    logic [CFG_SIZE_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[CFG_SIZE_W-1:0];
  endfunction

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    m_d    = m_q;
    dvd1_d = dvd1_q;
    dvd2_d = dvd2_q;
    rem1_d = rem1_q;
    rem2_d = rem2_q;
    if (start_i) begin
      // Load dividends, clear remainders
      busy_d = 1'b1;
      cnt_d  = '0;
      m_d    = m_i;
      dvd1_d = djb2_i;
      dvd2_d = sdbm_i;
      rem1_d = '0;
      rem2_d = '0;
    end else if (busy_q) begin
      // Advance one bit, most significant first
      rem1_d = rem_step(rem1_q, dvd1_q[HASH_WIDTH-1], m_q);
      rem2_d = rem_step(rem2_q, dvd2_q[HASH_WIDTH-1], m_q);
      dvd1_d = dvd1_q << 1;
      dvd2_d = dvd2_q << 1;
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    dvd1_q <= dvd1_d;
    dvd2_q <= dvd2_d;
    rem1_q <= rem1_d;
    rem2_q <= rem2_d;
  end

  assign res_o.valid = done_q;
  assign res_o.h1    = rem1_q;
  assign res_o.h2    = rem2_q;

endmodule

/* rtl/bfdh_probe.sv */
// Probe sequencer: clears the filter store after reset, then walks the k probe
// indices; inserts read-modify-write the store. Depends on bfdh_pkg, bfdh_ram.
module bfdh_probe import bfdh_pkg::*; #(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    mode_i,
  input  logic [CFG_SIZE_W-1:0]   m_i,
  input  logic [CFG_PROBES_W-1:0] k_i,
  input  reduce_res_t             red_i,
  output logic                    busy_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic                    hit_o
);

  localparam int unsigned Words = (FILTER_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [AddrW-1:0] AddrLast = AddrW'(Words - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_e;

  state_e                  state_q, state_d;
  logic [AddrW-1:0]        clr_q, clr_d;
  logic                    mode_q, mode_d;
  logic                    hit_q, hit_d;
  logic [CFG_SIZE_W-1:0]   idx_q, idx_d;
  logic [CFG_SIZE_W-1:0]   step_q, step_d;
  logic [CFG_PROBES_W-1:0] cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;

  logic                    mem_en, mem_we;
  logic [AddrW-1:0]        mem_addr;
  logic [WORD_W-1:0]       mem_wdata, mem_rdata;
  logic [WORD_W-1:0]       bit_mask;
  logic                    probe_bit;
  logic [CFG_SIZE_W:0]     idx_sum;
  logic [CFG_SIZE_W-1:0]   idx_next;
  logic [CFG_PROBES_W-1:0] cnt_inc;
  logic                    out_free;

  // Probe bit within its store word
  assign bit_mask  = WORD_W'(1) << idx_q[WORD_SH-1:0];
  assign probe_bit = mem_rdata[idx_q[WORD_SH-1:0]];

  // Next probe index: both terms are below m, so one subtract suffices
  assign idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
  assign idx_next = (idx_sum >= {1'b0, m_i}) ? CFG_SIZE_W'(idx_sum - {1'b0, m_i})
                                             : idx_sum[CFG_SIZE_W-1:0];
  assign cnt_inc  = cnt_q + CFG_PROBES_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Store port
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AddrW'(idx_q >> WORD_SH);
    mem_wdata = mem_rdata | bit_mask;
    case (state_q)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      S_READ: begin
        mem_en = 1'b1;
      end
      S_CHECK: begin
        mem_en = (mode_q == MODE_INSERT);
        mem_we = (mode_q == MODE_INSERT);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    out_hit_d   = out_hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          mode_d  = mode_i;
          hit_d   = 1'b1;
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (red_i.valid) begin
          idx_d  = red_i.h1;
          step_d = red_i.h2;
          cnt_d  = '0;
          if (k_i != '0) begin
            state_d = S_READ;
          end else if (mode_q == MODE_QUERY) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cnt_d = cnt_inc;
        idx_d = idx_next;
        if (mode_q == MODE_QUERY && !probe_bit) begin
          // Stop at the first clear bit
          hit_d   = 1'b0;
          state_d = S_RESULT;
        end else if (cnt_inc == k_i) begin
          state_d = (mode_q == MODE_QUERY) ? S_RESULT : S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_RESULT: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mode_q      <= MODE_INSERT;
      hit_q       <= 1'b1;
      idx_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mode_q      <= mode_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
    end
  end

  bfdh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (Words)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;

endmodule

/* rtl/bloom_filter_double_hash_top.sv */
// Bloom filter over byte-string keys with djb2/sdbm double hashing. Keys
// arrive one character per item; characters hash at one item per cycle
// while the input is not stalled. The item flagged key_last occupies the block
// from its accept cycle on: the shared reduction unit reduces both hashes in
// parallel, one remainder bit per cycle; the remainders are handed to the probe
// sequencer; each probe takes a read and then a test or write back on the single
// port of the filter store; a query then loads its result. A query stops at its
// first clear bit, and a result that waits behind a held-off output register
// holds the input stalled until it is loaded. Only queries give a result (hit).
// After reset the store is cleared one 64-bit word per cycle, all FILTER_BITS/64
// words (262144 at the default size), during which no item is accepted;
// configuration writes are always taken.
`include "bloom_filter_double_hash_top_assert.svh"

module bloom_filter_double_hash_top import bfdh_pkg::*; #(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned HASH_WIDTH  = HASH_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Key characters
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic signed [7:0]     key_char_i,
  input  logic                  char_present_i,
  input  logic                  key_last_i,
  // Query answers
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o
);

  // Largest usable modulus
  localparam logic [CFG_SIZE_W-1:0] SizeCap =
    (FILTER_BITS < (2 ** CFG_SIZE_W)) ? CFG_SIZE_W'(FILTER_BITS)
                                      : CFG_SIZE_W'((2 ** CFG_SIZE_W) - 1);

  logic [CFG_SIZE_W-1:0]   size_q, size_d;
  logic [CFG_PROBES_W-1:0] probes_q, probes_d;
  logic [CFG_SIZE_W-1:0]   m_eff;
  logic [CFG_PROBES_W-1:0] k_eff;
  logic                    in_accept;
  logic                    key_start;
  logic                    busy;
  logic [HASH_WIDTH-1:0]   djb2_next, sdbm_next;
  reduce_res_t             red_res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    size_d   = size_q;
    probes_d = probes_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_FILTER_SIZE: size_d   = cfg_wdata_i[CFG_SIZE_W-1:0];
        CFG_PROBE_COUNT: probes_d = cfg_wdata_i[CFG_PROBES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SIZE_RESET;
      probes_q <= PROBES_RESET;
    end else begin
      size_q   <= size_d;
      probes_q <= probes_d;
    end
  end

  // Clamp modulus to [1, SizeCap] and probe count to its maximum
  assign m_eff = (size_q == '0)     ? CFG_SIZE_W'(1) :
                 (size_q > SizeCap) ? SizeCap : size_q;
  assign k_eff = (probes_q > MAX_PROBES) ? MAX_PROBES : probes_q;

  // Input handshake
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign key_start  = in_accept && key_last_i;

  bfdh_hash #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_hash (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .key_char_i     (key_char_i),
    .char_present_i (char_present_i),
    .key_last_i     (key_last_i),
    .djb2_next_o    (djb2_next),
    .sdbm_next_o    (sdbm_next)
  );

  bfdh_reduce #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (key_start),
    .djb2_i  (djb2_next),
    .sdbm_i  (sdbm_next),
    .m_i     (m_eff),
    .res_o   (red_res)
  );

  bfdh_probe #(
    .FILTER_BITS (FILTER_BITS)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (key_start),
    .mode_i      (mode_i),
    .m_i         (m_eff),
    .k_i         (k_eff),
    .red_i       (red_res),
    .busy_o      (busy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o)
  );

  // A closing item locks out further items while it is worked off
  `BFDH_ASSERT_NEXT(a_last_locks_input, key_start, in_stall_o)
  // Reduced hashes only arrive while the sequencer is busy
  `BFDH_ASSERT_IMP(a_reduce_while_busy, red_res.valid, busy)
  // A new result only follows a busy cycle of the sequencer
  `BFDH_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), $past(busy))

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for bloom_filter_double_hash_top: key characters in, query hits out.
// Depends on bfdh_pkg and the block's RTL; it keeps its own model of the hashes and the store.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfdh_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 3;
  // longest key close: reduction, each probe's read and test or write back, and load, with margin
  localparam int unsigned SETTLE_CYCLES = 200;
  // must cover the store clearing pass after reset several times
  localparam int unsigned IDLE_LIMIT    = 1000000;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned PHASE_ITEMS   = 210;
  localparam int unsigned POOL_DEPTH    = 64;
  localparam int unsigned LONG_HOLD     = 1500;
  localparam int unsigned HOLD_SPACING  = 900;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_char;
    logic       char_present;
    logic       key_last;
    logic       wait_drain;
  } key_item_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i         = MODE_INSERT;
  logic signed [7:0]     key_char_i     = '0;
  logic                  char_present_i = 1'b0;
  logic                  key_last_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  hit_o;

  // Items waiting to be sent and query answers waiting to arrive
  key_item_t   char_queue[$];
  logic        expected_hits[$];
  logic [191:0] key_pool_text[$];
  int unsigned  key_pool_len[$];

  // Model of the block
  logic [CFG_SIZE_W-1:0]   filter_size_reg = SIZE_RESET;
  logic [CFG_PROBES_W-1:0] probe_count_reg = PROBES_RESET;
  logic [63:0]             djb2_acc        = 64'(DJB2_INIT);
  logic [63:0]             sdbm_acc        = '0;
  bit                      filter_marks[int unsigned];

  int unsigned items_accepted = 0;
  int unsigned answers_seen   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned fail_count     = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  int unsigned next_hold_mark = 300;
  logic        in_taken       = 1'b0;
  key_item_t   head_item;
  key_item_t   seen_item;
  logic        predicted_hit;

  bloom_filter_double_hash_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .key_char_i     (key_char_i),
    .char_present_i (char_present_i),
    .key_last_i     (key_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Mostly short gaps, a few long ones; none at all during calm stretches
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_REPORTS) $display("tb: mismatch: %s", what);
    fail_count++;
  endtask

  // Fold one character into both hashes; on the closing item probe the bit store
  task automatic hash_and_probe(input key_item_t item);
    logic [63:0] ch, m, h1, h2, idx;
    int unsigned k, i;
    logic        answer;
    if (item.char_present) begin
      ch = {{56{item.key_char[7]}}, item.key_char};
      djb2_acc = (djb2_acc << 5) + djb2_acc + ch;
      sdbm_acc = ch + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
    end
    if (!item.key_last) return;
    m = 64'(filter_size_reg);
    if (m == 64'd0) m = 64'd1;
    if (m > 64'(FILTER_BITS_DEF)) m = 64'(FILTER_BITS_DEF);
    k = 32'((probe_count_reg > MAX_PROBES) ? MAX_PROBES : probe_count_reg);
    h1 = djb2_acc % m;
    h2 = sdbm_acc % m;
    djb2_acc = 64'(DJB2_INIT);
    sdbm_acc = '0;
    answer = 1'b1;
    for (i = 0; i < k; i++) begin
      idx = (h1 + 64'(i) * h2) % m;
      if (item.mode == MODE_INSERT) begin
        filter_marks[idx[31:0]] = 1'b1;
      end else if (!filter_marks.exists(idx[31:0])) begin
        answer = 1'b0;
        break;
      end
    end
    if (item.mode == MODE_QUERY) expected_hits = {expected_hits, answer};
  endtask

  // Queue one key: chars low byte first, stray empty items mixed in now and then
  task automatic push_key(input logic op, input logic [191:0] text, input int unsigned len,
                          input bit drain);
    key_item_t   item;
    int unsigned j;
    if (len == 0) begin
      item.mode = op;
      item.key_char = 8'($urandom);
      item.char_present = 1'b0;
      item.key_last = 1'b1;
      item.wait_drain = drain;
      char_queue = {char_queue, item};
      return;
    end
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 99) < 5) begin
        item.mode = 1'($urandom);
        item.key_char = 8'($urandom);
        item.char_present = 1'b0;
        item.key_last = 1'b0;
        item.wait_drain = drain;
        char_queue = {char_queue, item};
        drain = 1'b0;
      end
      item.mode = (j == len - 1) ? op : 1'($urandom);
      item.key_char = text[j*8 +: 8];
      item.char_present = 1'b1;
      item.key_last = (j == len - 1);
      item.wait_drain = drain;
      char_queue = {char_queue, item};
      drain = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every item is taken and answered, then let the last key close
  task automatic settle_filter();
    do @(posedge clk_i); while (char_queue.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (expected_hits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sender: hold a stalled item, otherwise idle or present the next one
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (char_queue.size() != 0 &&
                   !(char_queue[0].wait_drain && expected_hits.size() != 0)) begin
        head_item = char_queue.pop_front();
        in_valid_i     <= 1'b1;
        mode_i         <= head_item.mode;
        key_char_i     <= head_item.key_char;
        char_present_i <= head_item.char_present;
        key_last_i     <= head_item.key_last;
        send_gap       <= pick_gap(((items_accepted / 64) % 3) == 0);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs that back the block up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (items_accepted >= next_hold_mark) begin
      out_stall_i    <= 1'b1;
      hold_left      <= LONG_HOLD;
      next_hold_mark <= next_hold_mark + HOLD_SPACING;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap(((answers_seen / 32) % 3) == 0);
    end
  end

  // Monitor: track config writes, predict on each taken item, check answers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == CFG_FILTER_SIZE) filter_size_reg = cfg_wdata_i[CFG_SIZE_W-1:0];
        else if (cfg_addr_i == CFG_PROBE_COUNT) probe_count_reg = cfg_wdata_i[CFG_PROBES_W-1:0];
      end
      if (in_valid_i && !in_stall_o) begin
        seen_item.mode         = mode_i;
        seen_item.key_char     = key_char_i;
        seen_item.char_present = char_present_i;
        seen_item.key_last     = key_last_i;
        seen_item.wait_drain   = 1'b0;
        hash_and_probe(seen_item);
        items_accepted <= items_accepted + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        answers_seen <= answers_seen + 1;
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("answer %0d arrived with no query waiting", answers_seen));
        end else begin
          predicted_hit = expected_hits.pop_front();
          if (hit_o !== predicted_hit)
            report_mismatch($sformatf("answer %0d: hit %b, predicted %b",
                                      answers_seen, hit_o, predicted_hit));
        end
      end
      // Watchdog on stretches with no traffic at all
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed keys at reset settings, then random phases under new settings
  initial begin
    int unsigned           phase, r, len, pick, keys_in_phase, phase_start;
    logic [191:0]          text;
    logic [CFG_DATA_W-1:0] size_word, probes_word;
    logic                  op;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme characters, reversed order, empty key, small and wrapping keys
    push_key(MODE_INSERT, 192'h807F, 2, 1'b0);
    push_key(MODE_QUERY, 192'h807F, 2, 1'b0);
    push_key(MODE_QUERY, 192'h7F80, 2, 1'b0);
    push_key(MODE_INSERT, '0, 0, 1'b0);
    push_key(MODE_QUERY, '0, 0, 1'b0);
    push_key(MODE_INSERT, 192'h0100FF, 3, 1'b0);
    push_key(MODE_QUERY, 192'h0100FF, 3, 1'b0);
    push_key(MODE_QUERY, 192'h00, 1, 1'b0);
    push_key(MODE_QUERY, {6{$urandom}}, 8, 1'b0);
    settle_filter();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin  // zero size acts as a single bit
          size_word = '0;
          probes_word = 32'd1;
        end
        1: begin
          size_word = 32'd64;
          probes_word = 32'd32;
        end
        2: begin  // oversized size and excess probes saturate
          size_word = '1;
          probes_word = '1;
        end
        3: begin  // zero probes: inserts do nothing, queries always hit
          size_word = 32'(FILTER_BITS_DEF);
          probes_word = '0;
        end
        4: begin
          size_word = 32'd1000;
          probes_word = 32'd6;
        end
        5: begin
          size_word = $urandom_range(2, 4096);
          probes_word = $urandom_range(1, 32);
        end
        6: begin
          size_word = $urandom_range(1, FILTER_BITS_DEF);
          probes_word = $urandom_range(33, 63);
        end
        default: begin
          size_word = 32'(FILTER_BITS_DEF - 1);
          probes_word = 32'd31;
        end
      endcase
      // Junk in the unused upper data bits must be dropped
      if (phase >= 4) begin
        size_word[CFG_DATA_W-1:CFG_SIZE_W]     = $urandom;
        probes_word[CFG_DATA_W-1:CFG_PROBES_W] = $urandom;
      end
      write_reg(CFG_FILTER_SIZE, size_word);
      write_reg(CFG_PROBE_COUNT, probes_word);
      // Unknown index: ignored
      write_reg(CFG_ADDR_W'($urandom_range(int'(CFG_PROBE_COUNT) + 1, (1 << CFG_ADDR_W) - 1)),
                $urandom);
      @(posedge clk_i);

      keys_in_phase = 0;
      phase_start = char_queue.size();
      while (char_queue.size() - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        text = {6{$urandom}};
        if (r < 45) begin
          len = $urandom_range(1, 8);
          push_key(MODE_INSERT, text, len, keys_in_phase == 25);
          key_pool_text = {key_pool_text, text};
          key_pool_len = {key_pool_len, len};
          if (key_pool_text.size() > POOL_DEPTH) begin
            void'(key_pool_text.pop_front());
            void'(key_pool_len.pop_front());
          end
        end else if (r < 80 && key_pool_text.size() != 0) begin
          pick = $urandom_range(0, key_pool_text.size() - 1);
          push_key(MODE_QUERY, key_pool_text[pick], key_pool_len[pick], keys_in_phase == 25);
        end else if (r < 90) begin
          push_key(MODE_QUERY, text, $urandom_range(1, 8), keys_in_phase == 25);
        end else begin
          op = $urandom_range(0, 1) ? MODE_QUERY : MODE_INSERT;
          len = (r < 95) ? 0 : $urandom_range(9, 24);
          push_key(op, text, len, keys_in_phase == 25);
        end
        keys_in_phase++;
      end
      settle_filter();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bfdh_pkg.sv
rtl/bfdh_ram.sv
rtl/bfdh_hash.sv
rtl/bfdh_reduce.sv
rtl/bfdh_probe.sv
rtl/bloom_filter_double_hash_top.sv
tb/sv/tb.sv
